>>> rtl/multichannel_block_averager_defines.svh
// ---------------------------------------------------------------------------
// multichannel_block_averager_defines
// Assertion helpers used by the block's datapath.
// ---------------------------------------------------------------------------
`ifndef MULTICHANNEL_BLOCK_AVERAGER_DEFINES_SVH
`define MULTICHANNEL_BLOCK_AVERAGER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MBAVG_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define MBAVG_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) 1'b1 |-> !(cond)) \
    else $error(msg);

`endif

>>> rtl/mbavg_pkg.sv
// ---------------------------------------------------------------------------
// mbavg_pkg
// Shared widths, constants and control types of the block averager.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mbavg_pkg;

  localparam int CHANNELS_DEF = 256;
  localparam int CH_IN_W      = 8;
  localparam int TS_W         = 48;
  localparam int VAL_W        = 32;
  localparam int CNT_W        = 8;
  localparam int TSUM_W       = 56;
  localparam int VSUM_W       = 40;
  localparam int ENTRY_W      = TSUM_W + VSUM_W + CNT_W;

  // one quotient bit per step over the full time-sum width
  localparam int DIV_STEPS    = TSUM_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] BLEN_RESET = CNT_W'(3);

  localparam int PADDR_W      = 3;
  localparam int PDATA_W      = 32;
  localparam int REG_IDX_W    = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BLOCK_LENGTH = '0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_DECIDE,
    ST_DIV,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic clear_we;
    logic load_in;
    logic rd_en;
    logic wr_en;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic in_range;
    logic emit;
    logic div_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/mbavg_ram.sv
// ---------------------------------------------------------------------------
// mbavg_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbavg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/mbavg_div.sv
// ---------------------------------------------------------------------------
// mbavg_div
// Restoring shift-subtract divider, one quotient bit per step.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbavg_div #(
  parameter int W  = 56,
  parameter int DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          start_i,
  input  wire logic          step_i,
  input  wire logic [W-1:0]  dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic      [W-1:0]  quotient_o
);

  logic [W-1:0]  quo_q, quo_d;
  logic [DW-1:0] rem_q, rem_d;
  logic [DW-1:0] dsr_q;
  logic [DW:0]   trial;
  logic          qbit;

  always_comb begin
    trial = {rem_q, quo_q[W-1]};
    qbit  = (trial >= {1'b0, dsr_q});
    rem_d = qbit ? DW'(trial - {1'b0, dsr_q}) : trial[DW-1:0];
    quo_d = {quo_q[W-2:0], qbit};
  end

  // dividend shifts out the top while quotient bits fill in the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (step_i) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> rtl/mbavg_datapath.sv
// ---------------------------------------------------------------------------
// mbavg_datapath
// Channel store, accumulate/restart update, dividers and result register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "multichannel_block_averager_defines.svh"

module mbavg_datapath #(
  parameter int CHANNELS = mbavg_pkg::CHANNELS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire mbavg_pkg::cmd_t                   cmd_i,
  output mbavg_pkg::status_t                     status_o,
  input  wire logic [mbavg_pkg::CNT_W-1:0]       blen_i,
  input  wire logic [mbavg_pkg::CH_IN_W-1:0]     channel_i,
  input  wire logic [mbavg_pkg::TS_W-1:0]        timestamp_i,
  input  wire logic signed [mbavg_pkg::VAL_W-1:0] sample_value_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [mbavg_pkg::CH_IN_W-1:0]          out_channel_o,
  output logic [mbavg_pkg::TS_W-1:0]             mean_time_o,
  output logic signed [mbavg_pkg::VAL_W-1:0]     mean_value_o,
  output logic [mbavg_pkg::CNT_W-1:0]            sample_count_o
);

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int TSUM_W = mbavg_pkg::TSUM_W;
  localparam int VSUM_W = mbavg_pkg::VSUM_W;
  localparam int CNT_W  = mbavg_pkg::CNT_W;
  localparam int VAL_W  = mbavg_pkg::VAL_W;
  localparam int TS_W   = mbavg_pkg::TS_W;

  // latched request
  logic [mbavg_pkg::CH_IN_W-1:0] ch_q;
  logic [TS_W-1:0]               ts_q;
  logic [VAL_W-1:0]              val_q;

  // clearing sweep
  logic [CH_W-1:0] clr_q;

  // division bookkeeping
  logic [mbavg_pkg::DIV_CNT_W-1:0] div_cnt_q;
  logic                            sign_q;
  logic [CNT_W-1:0]                emit_cnt_q;

  logic                  out_valid_q;
  logic [mbavg_pkg::CH_IN_W-1:0] out_ch_q;
  logic [TS_W-1:0]       mean_time_q;
  logic [VAL_W-1:0]      mean_value_q;
  logic [CNT_W-1:0]      out_cnt_q;

  logic [mbavg_pkg::ENTRY_W-1:0] rdata, wdata, new_entry;
  logic [TSUM_W-1:0] rd_tsum;
  logic [VSUM_W-1:0] rd_vsum;
  logic [CNT_W-1:0]  rd_cnt;
  logic [VSUM_W-1:0] val_ext;
  logic [VSUM_W-1:0] vmag;
  logic              accum;
  logic [CH_W-1:0]   ch_idx;
  logic [CH_W-1:0]   waddr;
  logic              we;
  logic [TSUM_W-1:0] q_time, q_val;
  logic [VAL_W-1:0]  q_val_lo;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ch_q  <= channel_i;
      ts_q  <= timestamp_i;
      val_q <= sample_value_i;
    end
  end

  assign ch_idx = CH_W'(ch_q);

  always_comb begin
    {rd_tsum, rd_vsum, rd_cnt} = rdata;
    val_ext = {{(VSUM_W - VAL_W){val_q[VAL_W-1]}}, val_q};
    accum   = (rd_cnt < blen_i);
    if (accum) begin
      new_entry = {rd_tsum + TSUM_W'(ts_q), rd_vsum + val_ext, CNT_W'(rd_cnt + 1'b1)};
    end else begin
      // restart the block with this request alone
      new_entry = {TSUM_W'(ts_q), val_ext, CNT_W'(1)};
    end
    vmag  = rd_vsum[VSUM_W-1] ? VSUM_W'(-rd_vsum) : rd_vsum;
    we    = cmd_i.clear_we | cmd_i.wr_en;
    waddr = cmd_i.clear_we ? clr_q : ch_idx;
    wdata = cmd_i.clear_we ? '0 : new_entry;
  end

  mbavg_ram #(
    .WIDTH (mbavg_pkg::ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (ch_idx),
    .rdata_o (rdata)
  );

  mbavg_div #(.W(TSUM_W), .DW(CNT_W)) u_div_time (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (rd_tsum),
    .divisor_i  (rd_cnt),
    .quotient_o (q_time)
  );

  mbavg_div #(.W(TSUM_W), .DW(CNT_W)) u_div_value (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i (TSUM_W'(vmag)),
    .divisor_i  (rd_cnt),
    .quotient_o (q_val)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      div_cnt_q <= '0;
    end else begin
      if (cmd_i.clear_we) begin
        clr_q <= CH_W'(clr_q + 1'b1);
      end
      if (cmd_i.div_start) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= mbavg_pkg::DIV_CNT_W'(div_cnt_q + 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      sign_q     <= rd_vsum[VSUM_W-1];
      emit_cnt_q <= rd_cnt;
    end
  end

  assign q_val_lo = q_val[VAL_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_ch_q     <= ch_q;
      mean_time_q  <= q_time[TS_W-1:0];
      mean_value_q <= sign_q ? VAL_W'(-q_val_lo) : q_val_lo;
      out_cnt_q    <= emit_cnt_q;
    end
  end

  always_comb begin
    status_o.clear_last = (clr_q == CH_W'(CHANNELS - 1));
    status_o.in_range   = (32'(ch_q) < 32'(CHANNELS));
    status_o.emit       = !accum && (rd_cnt != '0);
    status_o.div_last   = (div_cnt_q == mbavg_pkg::DIV_CNT_W'(mbavg_pkg::DIV_STEPS - 1));
    status_o.out_busy   = out_valid_q;
  end

  assign out_valid_o    = out_valid_q;
  assign out_channel_o  = out_ch_q;
  assign mean_time_o    = mean_time_q;
  assign mean_value_o   = mean_value_q;
  assign sample_count_o = out_cnt_q;

  `MBAVG_ASSERT_IMP(a_load_when_free, clk_i, rst_ni, cmd_i.out_load, !out_valid_q,
    "result register overwritten while still pending")
  `MBAVG_ASSERT_IMP(a_div_length, clk_i, rst_ni, cmd_i.div_start,
    ##(mbavg_pkg::DIV_STEPS) status_o.div_last, "division did not finish on time")
  `MBAVG_ASSERT_NEVER(a_count_nonzero, clk_i, rst_ni, out_valid_q && (out_cnt_q == '0),
    "average emitted with a zero sample count")

endmodule

`default_nettype wire

>>> rtl/mbavg_ctrl.sv
// ---------------------------------------------------------------------------
// mbavg_ctrl
// Sequencer: clearing sweep, read, update, divide and result hand-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mbavg_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mbavg_pkg::status_t status_i,
  output mbavg_pkg::cmd_t         cmd_o
);

  mbavg_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mbavg_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      mbavg_pkg::ST_CLEAR: begin
        cmd_o.clear_we = 1'b1;
        if (status_i.clear_last) begin
          state_d = mbavg_pkg::ST_IDLE;
        end
      end
      mbavg_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = mbavg_pkg::ST_READ;
        end
      end
      mbavg_pkg::ST_READ: begin
        // drop requests for channels outside the store
        if (status_i.in_range) begin
          cmd_o.rd_en = 1'b1;
          state_d     = mbavg_pkg::ST_DECIDE;
        end else begin
          state_d = mbavg_pkg::ST_IDLE;
        end
      end
      mbavg_pkg::ST_DECIDE: begin
        cmd_o.wr_en = 1'b1;
        if (status_i.emit) begin
          cmd_o.div_start = 1'b1;
          state_d         = mbavg_pkg::ST_DIV;
        end else begin
          state_d = mbavg_pkg::ST_IDLE;
        end
      end
      mbavg_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = mbavg_pkg::ST_HOLD;
        end
      end
      mbavg_pkg::ST_HOLD: begin
        // wait until the previous result has been taken
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = mbavg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = mbavg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/multichannel_block_averager.sv
// ---------------------------------------------------------------------------
// multichannel_block_averager
// Per-channel block averaging of timestamped samples with decimated output.
// ---------------------------------------------------------------------------
// Input requests (channel, timestamp, sample value) arrive on a valid/ready
// channel; averages leave on a second valid/ready channel. An APB port holds
// the block length register at address 0.
// A request that only accumulates reads the channel entry, updates it and
// returns to idle. A request that closes a block also runs the two
// shift-subtract dividers, which produce one quotient bit per cycle over the
// 56-bit sum width, then the result register is loaded.
// One request is in flight at a time; the next one is taken once the
// current one is done.
// After reset the channel store is swept to zero, one entry per cycle, over all
// CHANNELS entries; no request is accepted during the sweep, APB writes are.
// If the receiver stalls, the pending result stays in the output register;
// further requests are still taken, and a request that closes another block
// waits after its division until the register frees up.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module multichannel_block_averager #(
  parameter int CHANNELS = mbavg_pkg::CHANNELS_DEF
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [mbavg_pkg::PADDR_W-1:0]      paddr,
  input  wire logic [mbavg_pkg::PDATA_W-1:0]      pwdata,
  output logic      [mbavg_pkg::PDATA_W-1:0]      prdata,
  output logic                                    pready,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [mbavg_pkg::CH_IN_W-1:0]      channel_i,
  input  wire logic [mbavg_pkg::TS_W-1:0]         timestamp_i,
  input  wire logic signed [mbavg_pkg::VAL_W-1:0] sample_value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [mbavg_pkg::CH_IN_W-1:0]           out_channel_o,
  output logic [mbavg_pkg::TS_W-1:0]              mean_time_o,
  output logic signed [mbavg_pkg::VAL_W-1:0]      mean_value_o,
  output logic [mbavg_pkg::CNT_W-1:0]             sample_count_o
);

  logic [mbavg_pkg::CNT_W-1:0]     blen_q;
  logic [mbavg_pkg::REG_IDX_W-1:0] reg_idx;
  logic                            reg_hit;
  mbavg_pkg::cmd_t                 cmd;
  mbavg_pkg::status_t              status;

  assign reg_idx = paddr[mbavg_pkg::PADDR_W-1:2];
  assign reg_hit = (reg_idx == mbavg_pkg::REG_BLOCK_LENGTH);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q <= mbavg_pkg::BLEN_RESET;
    end else if (psel && penable && pwrite && reg_hit) begin
      blen_q <= pwdata[mbavg_pkg::CNT_W-1:0];
    end
  end

  assign prdata = reg_hit ? mbavg_pkg::PDATA_W'(blen_q) : '0;

  mbavg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mbavg_datapath #(
    .CHANNELS (CHANNELS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .blen_i         (blen_q),
    .channel_i      (channel_i),
    .timestamp_i    (timestamp_i),
    .sample_value_i (sample_value_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .out_channel_o  (out_channel_o),
    .mean_time_o    (mean_time_o),
    .mean_value_o   (mean_value_o),
    .sample_count_o (sample_count_o)
  );

endmodule

`default_nettype wire

>>> tb/multichannel_block_averager_tb.sv
// ---------------------------------------------------------------------------
// multichannel_block_averager_tb
// Self-checking testbench for the per-channel block averager.
// ---------------------------------------------------------------------------
// A short table of directed requests covers the field extremes, truncation
// toward zero, a block length lowered below a stored count, block length
// zero and empty blocks. Random phases follow, each at its own block length
// (1, 3, 255, 0 and random), mostly on a small pool of channels so that
// blocks fill. Every accepted request goes through a behavioral copy of the
// channel store. The averages it predicts are queued and compared field by
// field against the output channel. Both sides idle and stall at random.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module multichannel_block_averager_tb;
  import mbavg_pkg::*;

  localparam int SETTLE_CYCLES = 100;   // longer than one division
  localparam int WATCHDOG      = 2000;

  typedef struct packed {
    logic [CH_IN_W-1:0]      chan;
    logic [TS_W-1:0]         mtime;
    logic signed [VAL_W-1:0] mval;
    logic [CNT_W-1:0]        samples;
  } avg_t;

  typedef enum logic [1:0] {ROW_WRITE_BLEN, ROW_SAMPLE} row_kind_e;
  typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_TYPED} chk_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [CNT_W-1:0]        blen;
    logic [CH_IN_W-1:0]      chan;
    logic [TS_W-1:0]         ts;
    logic signed [VAL_W-1:0] val;
    chk_kind_e               chk;
    avg_t                    avg;
  } row_t;

  localparam avg_t NO_AVG = '0;
  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fffffff;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [PADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]        pwdata;
  logic [PDATA_W-1:0]        prdata;
  logic                      pready;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [CH_IN_W-1:0]        channel_i;
  logic [TS_W-1:0]           timestamp_i;
  logic signed [VAL_W-1:0]   sample_value_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic [CH_IN_W-1:0]        out_channel_o;
  logic [TS_W-1:0]           mean_time_o;
  logic signed [VAL_W-1:0]   mean_value_o;
  logic [CNT_W-1:0]          sample_count_o;

  multichannel_block_averager #(
    .CHANNELS(CHANNELS_DEF)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .channel_i     (channel_i),
    .timestamp_i   (timestamp_i),
    .sample_value_i(sample_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_channel_o (out_channel_o),
    .mean_time_o   (mean_time_o),
    .mean_value_o  (mean_value_o),
    .sample_count_o(sample_count_o)
  );

  // behavioral channel store
  logic [TSUM_W-1:0]        time_acc  [CHANNELS_DEF];
  logic signed [VSUM_W-1:0] value_acc [CHANNELS_DEF];
  logic [CNT_W-1:0]         fill      [CHANNELS_DEF];
  logic [CNT_W-1:0]         blen_model;

  avg_t      pending_avgs[$];
  row_t      dir_rows[$];
  chk_kind_e cur_chk;
  avg_t      cur_avg;
  bit        calm;
  int        errors;
  int        samples_in;
  int        avgs_out;
  int        quiet;
  int        stall_left;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Accumulate one request into the store; return the average it closes.
  task automatic block_avg_step(input logic [CH_IN_W-1:0] ch, input logic [TS_W-1:0] ts,
                                input logic signed [VAL_W-1:0] val,
                                output bit produced, output avg_t res);
    logic [TSUM_W-1:0] tq;
    longint            vq;
    produced = 1'b0;
    res      = '0;
    if (int'(ch) < CHANNELS_DEF) begin
      if (fill[ch] < blen_model) begin
        time_acc[ch]  += ts;
        value_acc[ch] += val;
        fill[ch]      += 1'b1;
      end else begin
        if (fill[ch] != '0) begin
          tq = time_acc[ch] / TSUM_W'(fill[ch]);
          vq = longint'(value_acc[ch]) / longint'(fill[ch]);
          res = '{ch, tq[TS_W-1:0], vq[VAL_W-1:0], fill[ch]};
          produced = 1'b1;
        end
        time_acc[ch]  = TSUM_W'(ts);
        value_acc[ch] = val;
        fill[ch]      = CNT_W'(1);
      end
    end
  endtask

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    errors++;
    $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
  endtask

  always @(posedge clk_i) begin : monitor
    bit   fired;
    bit   produced;
    avg_t predicted;
    avg_t got;
    avg_t want;
    if (rst_ni) begin
      fired = 1'b0;
      if (psel && penable && pwrite && pready) begin
        if (paddr[PADDR_W-1:2] == REG_BLOCK_LENGTH) blen_model = pwdata[CNT_W-1:0];
        fired = 1'b1;
      end
      if (in_valid_i && in_ready_o) begin
        block_avg_step(channel_i, timestamp_i, sample_value_i, produced, predicted);
        case (cur_chk)
          CHK_PREDICT: if (produced) pending_avgs.push_back(predicted);
          CHK_TYPED:   pending_avgs.push_back(cur_avg);
          default: ;
        endcase
        samples_in++;
        fired = 1'b1;
      end
      if (out_valid_o && out_ready_i) begin
        got = '{out_channel_o, mean_time_o, mean_value_o, sample_count_o};
        if (pending_avgs.size() == 0) begin
          errors++;
          $display("%0t: unexpected average, channel %0d count %0d", $time,
                   got.chan, got.samples);
        end else begin
          want = pending_avgs.pop_front();
          if (got.chan != want.chan) flag_mismatch("out_channel", want.chan, got.chan);
          if (got.mtime != want.mtime) flag_mismatch("mean_time", want.mtime, got.mtime);
          if (got.mval != want.mval) flag_mismatch("mean_value", want.mval, got.mval);
          if (got.samples != want.samples)
            flag_mismatch("sample_count", want.samples, got.samples);
        end
        avgs_out++;
        fired = 1'b1;
      end
      quiet = fired ? 0 : quiet + 1;
      if (quiet >= WATCHDOG) begin
        $display("%0t: no handshake for %0d cycles, %0d averages outstanding", $time,
                 quiet, pending_avgs.size());
        $display("multichannel_block_averager_tb: errors");
        $finish;
      end
    end
  end

  // mostly short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(16, 80);
  endfunction

  function automatic logic [TS_W-1:0] pick_ts();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return TS_MAX;
      default: return TS_W'({$urandom, $urandom});
    endcase
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_val();
    case ($urandom_range(0, 19))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2, 3:    return VAL_W'($signed($urandom_range(0, 15)) - 8);
      default: return VAL_W'($urandom);
    endcase
  endfunction

  // receiver: random stalls on the average channel
  initial begin
    out_ready_i = 1'b0;
    stall_left  = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // All driving tasks start and end at a falling edge.
  task automatic send_sample(input logic [CH_IN_W-1:0] ch, input logic [TS_W-1:0] ts,
                             input logic signed [VAL_W-1:0] val,
                             input chk_kind_e chk, input avg_t avg);
    int gap;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    channel_i      <= ch;
    timestamp_i    <= ts;
    sample_value_i <= val;
    cur_chk        <= chk;
    cur_avg        <= avg;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  // Hold requests until every average is out and the block has gone quiet.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_blen(input logic [CNT_W-1:0] v);
    logic [PDATA_W-1:0] rd;
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_BLOCK_LENGTH, 2'b00};
    pwdata  <= PDATA_W'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rd = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
    if (rd[CNT_W-1:0] != v) flag_mismatch("block_length readback", v, rd[CNT_W-1:0]);
  endtask

  task automatic add_blen(input logic [CNT_W-1:0] v);
    dir_rows.push_back('{ROW_WRITE_BLEN, v, '0, '0, '0, CHK_NONE, NO_AVG});
  endtask

  task automatic add_smp(input logic [CH_IN_W-1:0] ch, input logic [TS_W-1:0] ts,
                         input logic signed [VAL_W-1:0] val, input chk_kind_e chk,
                         input avg_t avg);
    dir_rows.push_back('{ROW_SAMPLE, '0, ch, ts, val, chk, avg});
  endtask

  initial begin : stimulus
    static int unsigned ph_blen  [6] = '{1, 3, 255, 0, 0, 0};
    static int          ph_items [6] = '{150, 150, 270, 100, 140, 140};
    static int          ph_pool  [6] = '{8, 16, 1, 8, 4, 32};
    int          pool     [32];
    int          p;
    int          i;
    int          k;
    logic [CH_IN_W-1:0] ch;
    logic [CNT_W-1:0]   nblen;

    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    in_valid_i     = 1'b0;
    channel_i      = '0;
    timestamp_i    = '0;
    sample_value_i = '0;
    cur_chk        = CHK_PREDICT;
    cur_avg        = NO_AVG;
    calm           = 1'b0;
    errors         = 0;
    samples_in     = 0;
    avgs_out       = 0;
    quiet          = 0;
    blen_model     = BLEN_RESET;
    for (k = 0; k < CHANNELS_DEF; k++) begin
      time_acc[k]  = '0;
      value_acc[k] = '0;
      fill[k]      = '0;
    end

    // zero store right after reset
    repeat (3) add_smp(8'd0, '0, '0, CHK_NONE, NO_AVG);
    add_smp(8'd0, 48'd10, 32'sd5, CHK_TYPED, '{8'd0, '0, '0, 8'd3});
    // largest timestamps and values
    repeat (3) add_smp(8'd255, TS_MAX, VAL_MAX, CHK_NONE, NO_AVG);
    add_smp(8'd255, 48'd100, -32'sd7, CHK_TYPED, '{8'd255, TS_MAX, VAL_MAX, 8'd3});
    // most negative value
    add_smp(8'd1, 48'd1, VAL_MIN, CHK_NONE, NO_AVG);
    add_smp(8'd1, 48'd2, VAL_MIN, CHK_NONE, NO_AVG);
    add_smp(8'd1, 48'd3, VAL_MIN, CHK_NONE, NO_AVG);
    add_smp(8'd1, 48'd0, 32'sd0, CHK_TYPED, '{8'd1, 48'd2, VAL_MIN, 8'd3});
    // negative sum truncates toward zero
    add_smp(8'd2, 48'd1, -32'sd1, CHK_NONE, NO_AVG);
    add_smp(8'd2, 48'd1, -32'sd1, CHK_NONE, NO_AVG);
    add_smp(8'd2, 48'd2, 32'sd1, CHK_NONE, NO_AVG);
    add_smp(8'd2, 48'd5, -32'sd5, CHK_TYPED, '{8'd2, 48'd1, 32'sd0, 8'd3});
    // lower the block length below a stored count
    add_blen(8'd5);
    add_smp(8'd3, 48'd1000, -32'sd100, CHK_PREDICT, NO_AVG);
    add_smp(8'd3, 48'd1001, -32'sd200, CHK_PREDICT, NO_AVG);
    add_smp(8'd3, 48'd1002, -32'sd300, CHK_PREDICT, NO_AVG);
    add_smp(8'd3, 48'd1003, -32'sd401, CHK_PREDICT, NO_AVG);
    add_blen(8'd2);
    add_smp(8'd3, 48'd0, 32'sd0, CHK_TYPED, '{8'd3, 48'd1001, -32'sd250, 8'd4});
    // block length zero: empty block gives nothing, then every request emits
    add_blen(8'd0);
    add_smp(8'd4, 48'd77, 32'sd123, CHK_NONE, NO_AVG);
    add_smp(8'd4, 48'd78, 32'sd0, CHK_TYPED, '{8'd4, 48'd77, 32'sd123, 8'd1});
    add_smp(8'd0, 48'd20, 32'sd0, CHK_TYPED, '{8'd0, 48'd10, 32'sd5, 8'd1});
    add_smp(8'd255, 48'd0, 32'sd1, CHK_TYPED, '{8'd255, 48'd100, -32'sd7, 8'd1});

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == ROW_WRITE_BLEN) begin
        write_blen(dir_rows[r].blen);
      end else begin
        send_sample(dir_rows[r].chan, dir_rows[r].ts, dir_rows[r].val, dir_rows[r].chk,
                    dir_rows[r].avg);
      end
    end

    for (p = 0; p < 6; p++) begin
      nblen = (p < 4) ? CNT_W'(ph_blen[p]) : CNT_W'($urandom_range(2, 40));
      write_blen(nblen);
      for (k = 0; k < ph_pool[p]; k++) pool[k] = $urandom_range(0, 255);
      for (i = 0; i < ph_items[p]; i++) begin
        if (i % 64 == 0) calm = ($urandom_range(0, 3) == 0);
        if (i == ph_items[p] / 2) wait_drained();
        if ($urandom_range(0, 9) == 0) ch = CH_IN_W'($urandom_range(0, 255));
        else ch = CH_IN_W'(pool[$urandom_range(0, ph_pool[p] - 1)]);
        send_sample(ch, pick_ts(), pick_val(), CHK_PREDICT, NO_AVG);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_avgs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("covered %0d samples and %0d block averages at block lengths 0, 1, 2, 3, 5,",
             samples_in, avgs_out);
    $display("255 and random, with stalls on both channels; %0d mismatches", errors);
    if (errors == 0 && pending_avgs.size() == 0) begin
      $display("multichannel_block_averager_tb: clean");
    end else begin
      $display("multichannel_block_averager_tb: errors");
    end
    $finish;
  end

endmodule
